>>> sv/tcrc_pkg.sv
// Package for the three-coil rotation counter: shared constants, codes,
// payload structs and the detect-map to phase table.
// No dependencies; every other file of the block imports it.
package tcrc_pkg;

  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned MAP_W      = 3;
  localparam int unsigned PHASE_W    = 8;
  localparam int unsigned HOME_W     = 3;
  localparam int unsigned CTR_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Classification queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [PHASE_W-1:0] PH_NONE   = 8'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST  = 8'd1;
  localparam logic [PHASE_W-1:0] PH_MID    = 8'd4;
  localparam logic [PHASE_W-1:0] PH_LAST   = 8'd6;
  localparam logic [PHASE_W-1:0] PH_FAULT2 = 8'd7;
  localparam logic [PHASE_W-1:0] PH_FAULT3 = 8'hFF;

  localparam logic [HOME_W-1:0] HOME_RESET = 3'd4;

  // Detect-map codes: bit2 coil 1, bit1 coil 2, bit0 coil 3
  localparam logic [MAP_W-1:0] MAP_NONE   = 3'b000;
  localparam logic [MAP_W-1:0] MAP_C3     = 3'b001;
  localparam logic [MAP_W-1:0] MAP_C2     = 3'b010;
  localparam logic [MAP_W-1:0] MAP_C2C3   = 3'b011;
  localparam logic [MAP_W-1:0] MAP_C1     = 3'b100;
  localparam logic [MAP_W-1:0] MAP_C1C3   = 3'b101;
  localparam logic [MAP_W-1:0] MAP_C1C2   = 3'b110;
  localparam logic [MAP_W-1:0] MAP_ALL    = 3'b111;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR1   = 3'd0,
    CFG_THR2   = 3'd1,
    CFG_THR3   = 3'd2,
    CFG_HOME   = 3'd3,
    CFG_OFFSET = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [COUNT_W-1:0] thr1;
    logic [COUNT_W-1:0] thr2;
    logic [COUNT_W-1:0] thr3;
  } thr_cfg_t;

  // One classified round, as it travels through the queue
  typedef struct packed {
    logic [MAP_W-1:0]   detect_map;
    logic [PHASE_W-1:0] raw_phase;
  } cls_t;

  typedef struct packed {
    logic [MAP_W-1:0]   detect_map;
    logic [PHASE_W-1:0] phase;
    logic               direction;
    logic [CTR_W-1:0]   fwd_steps;
    logic [CTR_W-1:0]   bwd_steps;
    logic [CTR_W-1:0]   fwd_revs;
    logic [CTR_W-1:0]   bwd_revs;
    logic [CTR_W-1:0]   meter;
  } res_t;

  function automatic logic [PHASE_W-1:0] phase_of_map(input logic [MAP_W-1:0] m);
    logic [PHASE_W-1:0] p;
    case (m)
      MAP_NONE: p = PH_FAULT2;
      MAP_C3:   p = PH_LAST;
      MAP_C2:   p = PH_MID;
      MAP_C2C3: p = PH_MID;
      MAP_C1:   p = PH_FIRST;
      MAP_C1C3: p = PH_LAST;
      MAP_C1C2: p = PH_FIRST;
      MAP_ALL:  p = PH_FAULT3;
      default:  p = PH_FAULT3;
    endcase
    return p;
  endfunction

endpackage

>>> sv/tcrc_in_if.sv
// Input channel of the rotation counter: valid/ready plus three coil counts.
// Depends on tcrc_pkg.
interface tcrc_in_if;
  import tcrc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count_coil1;
  logic [COUNT_W-1:0] count_coil2;
  logic [COUNT_W-1:0] count_coil3;

  modport source (output valid, output count_coil1, output count_coil2,
                  output count_coil3, input ready);
  modport sink   (input valid, input count_coil1, input count_coil2,
                  input count_coil3, output ready);
endinterface

>>> sv/tcrc_out_if.sv
// Result channel of the rotation counter: valid/ready plus the result fields.
// Depends on tcrc_pkg.
interface tcrc_out_if;
  import tcrc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MAP_W-1:0]          detect_map;
  logic [PHASE_W-1:0]        phase;
  logic                      direction;
  logic [CTR_W-1:0]          forward_transitions;
  logic [CTR_W-1:0]          backward_transitions;
  logic [CTR_W-1:0]          forward_revolutions;
  logic [CTR_W-1:0]          backward_revolutions;
  logic signed [CTR_W-1:0]   meter_value;

  modport source (output valid, output detect_map, output phase, output direction,
                  output forward_transitions, output backward_transitions,
                  output forward_revolutions, output backward_revolutions,
                  output meter_value, input ready);
  modport sink   (input valid, input detect_map, input phase, input direction,
                  input forward_transitions, input backward_transitions,
                  input forward_revolutions, input backward_revolutions,
                  input meter_value, output ready);
endinterface

>>> sv/three_coil_rotation_counter_core.sv
// Three-coil rotation counter, top level. Each input beat carries the coil
// counts of one sampling round and yields exactly one result beat with the
// detect map, the phase after fault substitution, the last direction, the
// transition and revolution counters and the meter value. A new round is
// accepted every cycle while the queue has room; each round passes through
// the classification queue and then the result register, and a stalled
// result stops the flow only once the two-entry queue between classifier
// and counter has filled. Write configuration registers only while no
// results are pending. Depends on tcrc_pkg, tcrc_in_if, tcrc_out_if,
// tcrc_front, tcrc_queue and tcrc_back.
module three_coil_rotation_counter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcrc_pkg::CFG_DATA_W-1:0] cfg_data,
  tcrc_in_if.sink                         in_chan,
  tcrc_out_if.source                      out_chan
);
  import tcrc_pkg::*;

  thr_cfg_t          thr_r;
  logic [HOME_W-1:0] home_r;
  logic [CTR_W-1:0]  offset_r;

  logic q_push, q_push_ready, q_pop, q_valid;
  cls_t q_in, q_out;
  res_t res;

  // Configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= '0;
      home_r   <= HOME_RESET;
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THR1:   thr_r.thr1 <= cfg_data[COUNT_W-1:0];
        CFG_THR2:   thr_r.thr2 <= cfg_data[COUNT_W-1:0];
        CFG_THR3:   thr_r.thr3 <= cfg_data[COUNT_W-1:0];
        CFG_HOME:   home_r     <= cfg_data[HOME_W-1:0];
        CFG_OFFSET: offset_r   <= cfg_data[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify each beat as it arrives
  tcrc_front u_front (
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .count_coil1 (in_chan.count_coil1),
    .count_coil2 (in_chan.count_coil2),
    .count_coil3 (in_chan.count_coil3),
    .thr         (thr_r),
    .q_ready     (q_push_ready),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  // Decouple classifier from counter so each side stalls on its own
  tcrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  // Advance the phase tracker and counters, hold the result until taken
  tcrc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .home_phase   (home_r),
    .value_offset (offset_r),
    .res_valid    (out_chan.valid),
    .res_ready    (out_chan.ready),
    .res          (res)
  );

  assign out_chan.detect_map           = res.detect_map;
  assign out_chan.phase                = res.phase;
  assign out_chan.direction            = res.direction;
  assign out_chan.forward_transitions  = res.fwd_steps;
  assign out_chan.backward_transitions = res.bwd_steps;
  assign out_chan.forward_revolutions  = res.fwd_revs;
  assign out_chan.backward_revolutions = res.bwd_revs;
  assign out_chan.meter_value          = $signed(res.meter);

endmodule

>>> sv/tcrc_front.sv
// Front part: compares the coil counts against their thresholds, builds the
// detect map and looks up the raw phase. Depends on tcrc_pkg.
module tcrc_front (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [tcrc_pkg::COUNT_W-1:0] count_coil1,
  input  logic [tcrc_pkg::COUNT_W-1:0] count_coil2,
  input  logic [tcrc_pkg::COUNT_W-1:0] count_coil3,
  input  tcrc_pkg::thr_cfg_t       thr,
  input  logic                     q_ready,
  output logic                     q_push,
  output tcrc_pkg::cls_t           q_data
);
  import tcrc_pkg::*;

  logic [MAP_W-1:0] map;

  // A coil reports the target when its count is at or below threshold
  assign map = {count_coil1 <= thr.thr1, count_coil2 <= thr.thr2, count_coil3 <= thr.thr3};

  assign in_ready          = q_ready;
  assign q_push            = in_valid && q_ready;
  assign q_data.detect_map = map;
  assign q_data.raw_phase  = phase_of_map(map);

endmodule

>>> sv/tcrc_queue.sv
// Short FIFO of classified rounds between front and back.
// Depends on tcrc_pkg (depth, pointer widths, cls_t).
module tcrc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcrc_pkg::cls_t push_data,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output tcrc_pkg::cls_t pop_data
);
  import tcrc_pkg::*;

  cls_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
    logic [Q_AW-1:0] r;
    if (p == Q_AW'(Q_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + Q_AW'(1);
    end
    return r;
  endfunction

  assign push_ready = (count_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue popped while empty");

endmodule

>>> sv/tcrc_back.sv
// Back part: fault substitution, transition and revolution counting, and the
// result register. Depends on tcrc_pkg.
module tcrc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  tcrc_pkg::cls_t               q_data,
  output logic                         q_pop,
  input  logic [tcrc_pkg::HOME_W-1:0]  home_phase,
  input  logic [tcrc_pkg::CTR_W-1:0]   value_offset,
  output logic                         res_valid,
  input  logic                         res_ready,
  output tcrc_pkg::res_t               res
);
  import tcrc_pkg::*;

  logic               valid_r, valid_nxt;
  logic [MAP_W-1:0]   map_r;
  logic [PHASE_W-1:0] last_phase_r, last_phase_nxt;
  logic               dir_r, dir_nxt;
  logic [CTR_W-1:0]   fwd_step_r, fwd_step_nxt;
  logic [CTR_W-1:0]   bwd_step_r, bwd_step_nxt;
  logic [CTR_W-1:0]   fwd_rev_r, fwd_rev_nxt;
  logic [CTR_W-1:0]   bwd_rev_r, bwd_rev_nxt;
  logic [CTR_W-1:0]   net_r, net_nxt;

  logic [PHASE_W-1:0] was_phase, now, home_ext;
  logic               is_fault, wrap_f, wrap_b, go_fwd, go_bwd;

  // Take a new round whenever the result register is free or being drained
  assign q_pop = q_valid && (!valid_r || res_ready);

  always_comb begin
    was_phase = last_phase_r;
    home_ext  = {{(PHASE_W-HOME_W){1'b0}}, home_phase};
    is_fault  = (q_data.raw_phase == PH_FAULT2) || (q_data.raw_phase == PH_FAULT3);
    now       = (is_fault && was_phase != PH_NONE) ? was_phase : q_data.raw_phase;
    wrap_f    = (now == PH_FIRST) && (was_phase == PH_LAST);
    wrap_b    = (now == PH_LAST) && (was_phase == PH_FIRST);
    go_fwd    = wrap_f || (!wrap_b && now > was_phase);
    go_bwd    = wrap_b || (!wrap_f && now < was_phase);
  end

  always_comb begin
    valid_nxt      = valid_r;
    last_phase_nxt = last_phase_r;
    dir_nxt        = dir_r;
    fwd_step_nxt   = fwd_step_r;
    bwd_step_nxt   = bwd_step_r;
    fwd_rev_nxt    = fwd_rev_r;
    bwd_rev_nxt    = bwd_rev_r;
    net_nxt        = net_r;
    if (res_ready) begin
      valid_nxt = 1'b0;
    end
    if (q_pop) begin
      valid_nxt      = 1'b1;
      last_phase_nxt = now;
      if (go_fwd) begin
        fwd_step_nxt = fwd_step_r + CTR_W'(1);
        dir_nxt      = 1'b0;
        if (now == home_ext) begin
          fwd_rev_nxt = fwd_rev_r + CTR_W'(1);
          net_nxt     = net_r + CTR_W'(1);
        end
      end else if (go_bwd) begin
        bwd_step_nxt = bwd_step_r + CTR_W'(1);
        dir_nxt      = 1'b1;
        if (was_phase == home_ext) begin
          bwd_rev_nxt = bwd_rev_r + CTR_W'(1);
          net_nxt     = net_r - CTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      last_phase_r <= PH_NONE;
      dir_r        <= 1'b0;
      fwd_step_r   <= '0;
      bwd_step_r   <= '0;
      fwd_rev_r    <= '0;
      bwd_rev_r    <= '0;
      net_r        <= '0;
    end else begin
      valid_r      <= valid_nxt;
      last_phase_r <= last_phase_nxt;
      dir_r        <= dir_nxt;
      fwd_step_r   <= fwd_step_nxt;
      bwd_step_r   <= bwd_step_nxt;
      fwd_rev_r    <= fwd_rev_nxt;
      bwd_rev_r    <= bwd_rev_nxt;
      net_r        <= net_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      map_r <= q_data.detect_map;
    end
  end

  // The state registers double as the result register
  assign res_valid      = valid_r;
  assign res.detect_map = map_r;
  assign res.phase      = last_phase_r;
  assign res.direction  = dir_r;
  assign res.fwd_steps  = fwd_step_r;
  assign res.bwd_steps  = bwd_step_r;
  assign res.fwd_revs   = fwd_rev_r;
  assign res.bwd_revs   = bwd_rev_r;
  assign res.meter      = net_r + value_offset;

  a_net_matches: assert property (@(posedge clk) disable iff (!rst_n)
    net_r == fwd_rev_r - bwd_rev_r)
    else $error("net revolution count out of step with counters");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !q_pop) |=> ($stable(fwd_step_r) && $stable(bwd_step_r)
                           && $stable(last_phase_r)))
    else $error("state changed without a round");

  a_fwd_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && q_pop && go_fwd) |=> !dir_r)
    else $error("forward step left direction backward");

  a_one_way: assert property (@(posedge clk) disable iff (!rst_n)
    !(go_fwd && go_bwd))
    else $error("round classified both forward and backward");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for three_coil_rotation_counter_core: directed and random
// coil rounds, a scoreboard that predicts every result beat. Needs tcrc_pkg,
// tcrc_in_if, tcrc_out_if and the core with its submodules.
module tb_top;
  import tcrc_pkg::*;

  localparam int          CLK_PERIOD_NS = 8;
  localparam int unsigned RESET_CYCLES  = 12;
  // Margin after draining the core, before any register write
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned CFG_REG_COUNT = 5;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ROUNDS  = 215;
  localparam int unsigned WATCHDOG_CYCLES = 400000;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // Tracks the counter state and thresholds, and holds the expected result
  // beats in acceptance order.
  class rotation_scoreboard;
    logic [COUNT_W-1:0] thr [3];
    logic [HOME_W-1:0]  home;
    logic [CTR_W-1:0]   offset;
    logic [PHASE_W-1:0] prev_phase;
    logic               dir;
    logic [CTR_W-1:0]   fwd_steps;
    logic [CTR_W-1:0]   bwd_steps;
    logic [CTR_W-1:0]   fwd_revs;
    logic [CTR_W-1:0]   bwd_revs;
    logic [PHASE_W-1:0] phase_lut [8];
    res_t               expected_q [$];
    int unsigned        mismatches;

    function new();
      thr        = '{default: '0};
      home       = HOME_RESET;
      offset     = '0;
      prev_phase = PH_NONE;
      dir        = 1'b0;
      fwd_steps  = '0;
      bwd_steps  = '0;
      fwd_revs   = '0;
      bwd_revs   = '0;
      mismatches = 0;
      phase_lut[MAP_NONE] = PH_FAULT2;
      phase_lut[MAP_C3]   = PH_LAST;
      phase_lut[MAP_C2]   = PH_MID;
      phase_lut[MAP_C2C3] = PH_MID;
      phase_lut[MAP_C1]   = PH_FIRST;
      phase_lut[MAP_C1C3] = PH_LAST;
      phase_lut[MAP_C1C2] = PH_FIRST;
      phase_lut[MAP_ALL]  = PH_FAULT3;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THR1:   thr[0] = data[COUNT_W-1:0];
        CFG_THR2:   thr[1] = data[COUNT_W-1:0];
        CFG_THR3:   thr[2] = data[COUNT_W-1:0];
        CFG_HOME:   home   = data[HOME_W-1:0];
        CFG_OFFSET: offset = data[CTR_W-1:0];
        default: ;
      endcase
    endfunction

    function bit at_home(logic [PHASE_W-1:0] p);
      return {{(PHASE_W-HOME_W){1'b0}}, home} == p;
    endfunction

    function void step_forward(logic [PHASE_W-1:0] now);
      fwd_steps++;
      if (at_home(now)) fwd_revs++;
      dir = 1'b0;
    endfunction

    function void step_backward(logic [PHASE_W-1:0] was);
      bwd_steps++;
      if (at_home(was)) bwd_revs++;
      dir = 1'b1;
    endfunction

    function void note_round(logic [COUNT_W-1:0] c1, logic [COUNT_W-1:0] c2,
                             logic [COUNT_W-1:0] c3);
      logic [MAP_W-1:0]   m;
      logic [PHASE_W-1:0] now;
      logic [PHASE_W-1:0] was;
      res_t               r;
      m   = {c1 <= thr[0], c2 <= thr[1], c3 <= thr[2]};
      now = phase_lut[m];
      was = prev_phase;
      if ((now == PH_FAULT2 || now == PH_FAULT3) && was != PH_NONE) now = was;
      if (now == PH_FIRST && was == PH_LAST)      step_forward(now);
      else if (now == PH_LAST && was == PH_FIRST) step_backward(was);
      else if (now > was)                         step_forward(now);
      else if (now < was)                         step_backward(was);
      prev_phase   = now;
      r.detect_map = m;
      r.phase      = now;
      r.direction  = dir;
      r.fwd_steps  = fwd_steps;
      r.bwd_steps  = bwd_steps;
      r.fwd_revs   = fwd_revs;
      r.bwd_revs   = bwd_revs;
      r.meter      = fwd_revs - bwd_revs + offset;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [CTR_W-1:0] want, logic [CTR_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result beat with nothing expected", $realtime);
        return;
      end
      want = expected_q.pop_front();
      compare_field("detect_map", CTR_W'(want.detect_map), CTR_W'(got.detect_map));
      compare_field("phase", CTR_W'(want.phase), CTR_W'(got.phase));
      compare_field("direction", CTR_W'(want.direction), CTR_W'(got.direction));
      compare_field("forward_transitions", want.fwd_steps, got.fwd_steps);
      compare_field("backward_transitions", want.bwd_steps, got.bwd_steps);
      compare_field("forward_revolutions", want.fwd_revs, got.fwd_revs);
      compare_field("backward_revolutions", want.bwd_revs, got.bwd_revs);
      compare_field("meter_value", want.meter, got.meter);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcrc_in_if  in_bus ();
  tcrc_out_if out_bus ();

  rotation_scoreboard sb;
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;

  three_coil_rotation_counter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD_NS / 2) clk = ~clk;

  // Receiver side: drop ready at random according to the current idle mode.
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watch both channels. Everything is driven by nonblocking assignments, so
  // the values read here are the ones present at the edge.
  always @(posedge clk) begin : watch_beats
    res_t seen;
    if (rst_n === 1'b1) begin
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
        sb.note_round(in_bus.count_coil1, in_bus.count_coil2, in_bus.count_coil3);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        seen.detect_map = out_bus.detect_map;
        seen.phase      = out_bus.phase;
        seen.direction  = out_bus.direction;
        seen.fwd_steps  = out_bus.forward_transitions;
        seen.bwd_steps  = out_bus.backward_transitions;
        seen.fwd_revs   = out_bus.forward_revolutions;
        seen.bwd_revs   = out_bus.backward_revolutions;
        seen.meter      = out_bus.meter_value;
        sb.check_result(seen);
      end
    end
  end

  // Hard stop in case the core hangs or loses beats.
  initial begin
    #(CLK_PERIOD_NS * WATCHDOG_CYCLES);
    $display("simulation failed");
    $finish;
  end

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 52; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 52; end
      default:       begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  // Offer one round; idle first at random, then hold valid until the beat
  // is taken. Valid stays high on return so back-to-back beats need no gap.
  task automatic send_round(input logic [COUNT_W-1:0] c1, input logic [COUNT_W-1:0] c2,
                            input logic [COUNT_W-1:0] c3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.count_coil1 <= c1;
    in_bus.count_coil2 <= c2;
    in_bus.count_coil3 <= c3;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  // Pick a count that lands on the wanted side of the threshold. With a
  // threshold at full scale a coil can't be absent, so any count will do.
  function automatic logic [COUNT_W-1:0] count_for(input bit present,
                                                   input logic [COUNT_W-1:0] thr);
    int unsigned lo;
    if (present) return COUNT_W'($urandom_range(thr, 0));
    if (thr == '1) return COUNT_W'($urandom);
    lo = thr;
    lo = lo + 1;
    return COUNT_W'($urandom_range(2**COUNT_W - 1, lo));
  endfunction

  task automatic send_map(input logic [MAP_W-1:0] m);
    send_round(count_for(m[2], sb.thr[0]), count_for(m[1], sb.thr[1]),
               count_for(m[0], sb.thr[2]));
  endtask

  // Stop offering and wait until every expected beat has come out.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // Write all five registers, junk above the thresholds and home, then a
  // write to an unused index that must change nothing. Call only while drained.
  task automatic load_settings(input logic [COUNT_W-1:0] t1, input logic [COUNT_W-1:0] t2,
                               input logic [COUNT_W-1:0] t3, input logic [HOME_W-1:0] hp,
                               input logic [CTR_W-1:0] ofs);
    write_reg(CFG_THR1, {16'($urandom), t1});
    write_reg(CFG_THR2, {16'($urandom), t2});
    write_reg(CFG_THR3, {16'($urandom), t3});
    write_reg(CFG_HOME, {29'($urandom), hp});
    write_reg(CFG_OFFSET, ofs);
    write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_REG_COUNT)), $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a rotor walking through 1, 4, 6 with direction changes and
  // jitter, some fault maps, and some rounds of raw noise.
  task automatic run_random(input int unsigned n_rounds, input bit pause_midway);
    int               pos;
    int               step_dir;
    int unsigned      k;
    int unsigned      roll;
    int unsigned      move;
    logic [MAP_W-1:0] m;
    pos      = $urandom_range(2);
    step_dir = 1;
    for (k = 0; k < n_rounds; k++) begin
      // Hold off the sender until the core has emptied
      if (pause_midway && k == n_rounds / 2) drain();
      roll = $urandom_range(99);
      if (roll < 15) begin
        send_round(COUNT_W'($urandom), COUNT_W'($urandom), COUNT_W'($urandom));
      end else if (roll < 25) begin
        m = $urandom_range(1) ? MAP_NONE : MAP_ALL;
        send_map(m);
      end else begin
        if ($urandom_range(99) < 20) step_dir = -step_dir;
        move = $urandom_range(99);
        if (move < 70)      pos = (pos + 3 + step_dir) % 3;
        else if (move > 85) pos = (pos + 3 - step_dir) % 3;
        case (pos)
          0:       m = $urandom_range(1) ? MAP_C1 : MAP_C1C2;
          1:       m = $urandom_range(1) ? MAP_C2 : MAP_C2C3;
          default: m = $urandom_range(1) ? MAP_C3 : MAP_C1C3;
        endcase
        send_map(m);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned        p;
    logic [COUNT_W-1:0] t [3];
    logic [CTR_W-1:0]   ofs;
    sb = new();
    set_idle_mode(IDLE_NONE);
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.count_coil1 <= '0;
    in_bus.count_coil2 <= '0;
    in_bus.count_coil3 <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Home at 7 before the first round: an empty map then keeps its fault
    // phase, counts as forward and lands on home. Offset at the top so the
    // meter wraps.
    load_settings(16'h8000, 16'h8000, 16'h8000, 3'd7, 32'h7FFF_FFFF);
    send_round(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_round(16'h0000, 16'h0000, 16'h0000);
    // Leave 7 backward, then a full turn forward with the 6 to 1 wrap
    send_map(MAP_C1);
    send_map(MAP_C2);
    send_map(MAP_C3);
    send_map(MAP_C1C2);
    // Backward, 1 to 6 wrap first
    send_map(MAP_C1C3);
    send_map(MAP_C2C3);
    send_map(MAP_C1);
    // Faults after a real phase take the previous one
    send_map(MAP_NONE);
    send_map(MAP_ALL);
    // Counts exactly at and just above the thresholds
    send_round(16'h8000, 16'h8000, 16'h8000);
    send_round(16'h8001, 16'h8001, 16'h8001);
    send_round(16'h0000, 16'hFFFF, 16'h0000);
    send_round(16'hFFFF, 16'h0000, 16'hFFFF);
    drain();

    // Default home, offset at the bottom: revolutions through 4 both ways
    load_settings(16'h0000, 16'hFFFE, 16'h1234, HOME_RESET, 32'h8000_0000);
    send_map(MAP_C1);
    send_map(MAP_C2);
    send_map(MAP_C3);
    send_map(MAP_C1);
    send_map(MAP_C3);
    send_map(MAP_C2);
    send_map(MAP_C1);
    send_map(MAP_C2);
    drain();

    // Random phases: each its own settings and idle mode
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        2:       t = '{16'h0000, 16'h0000, 16'h0000};
        5:       t = '{16'hFFFF, 16'h0000, COUNT_W'($urandom)};
        6:       t = '{16'h0000, 16'hFFFF, 16'hFFFF};
        default: t = '{COUNT_W'($urandom_range(16'hFFFE, 1)),
                       COUNT_W'($urandom_range(16'hFFFE, 1)),
                       COUNT_W'($urandom_range(16'hFFFE, 1))};
      endcase
      case (p)
        0:       ofs = 32'h7FFF_FFFF;
        1:       ofs = 32'h8000_0000;
        3:       ofs = '0;
        default: ofs = $urandom;
      endcase
      load_settings(t[0], t[1], t[2], HOME_W'(p), ofs);
      set_idle_mode(idle_mode_t'(p % 4));
      run_random(PHASE_ROUNDS, p == 1 || p == 6);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> three_coil_rotation_counter_core.f
sv/tcrc_pkg.sv
sv/tcrc_in_if.sv
sv/tcrc_out_if.sv
sv/tcrc_front.sv
sv/tcrc_queue.sv
sv/tcrc_back.sv
sv/three_coil_rotation_counter_core.sv
sim/tb_top.sv
